@@ design/uart_rut_pkg.sv @@
`default_nettype none

package uart_rut_pkg;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_BYTE  = 2'd1;
	localparam logic [1:0] CMD_IDLE  = 2'd2;

	localparam logic [1:0] REG_BUFFER_SIZE = 2'd0;
	localparam logic [1:0] REG_EOL_ENABLE  = 2'd1;
	localparam logic [1:0] REG_EOL_LENGTH  = 2'd2;
	localparam logic [1:0] REG_EOL_PATTERN = 2'd3;

	localparam logic [7:0] COUNT_MAX = 8'd255;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [7:0]  buffer_size;
		logic        eol_enable;
		logic [2:0]  eol_length;
		logic [31:0] eol_pattern;
	} cfg_t;

	typedef struct packed {
		logic       store_valid;
		logic [7:0] store_index;
		logic [7:0] store_byte;
		logic       done_res;
		logic [7:0] done_count;
		logic       idle_seen;
	} res_t;

endpackage

`default_nettype wire

@@ design/uart_receive_until_terminator.sv @@
// Channel  Dir  Handshake            Payload
// s        in   s_tvalid/s_tready    s_tdata: rx_byte; s_tuser: cmd
// m        out  m_tvalid/m_tready    m_tdata: store fields, done_count; m_tlast: done_res;
//                                    m_tuser: idle_seen
// cfg      in   cfg_we               cfg_index, cfg_wdata
//
// One beat in, one beat out; one beat per cycle sustained while m_tready holds, through
// the input register, then the result register.
// arst_n clears the reception state and loads the register reset values.
// A stalled m side holds the result register; the input register then holds and
// s_tready drops until the result beat is taken.
`default_nettype none

module uart_receive_until_terminator #(
	parameter int MAX_EOL = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic [1:0]  s_tuser,   // [1:0] cmd
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [31:0] m_tdata,   // [0] store_valid, [8:1] store_index,
	                                    // [16:9] store_byte, [24:17] done_count
	output      logic        m_tlast,   // done_res
	output      logic        m_tuser,   // idle_seen
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata
);

	uart_rut_pkg::cfg_t  cfg_q;
	uart_rut_pkg::item_t item_s1;
	logic                v_s1;
	uart_rut_pkg::res_t  res_c;
	uart_rut_pkg::res_t  res_s2;
	logic                v_s2;
	logic                adv;
	logic                take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buffer_size <= 8'd255;
			cfg_q.eol_enable  <= 1'b0;
			cfg_q.eol_length  <= 3'd1;
			cfg_q.eol_pattern <= 32'd10;
		end else if (cfg_we) begin
			unique case (cfg_index)
				uart_rut_pkg::REG_BUFFER_SIZE: cfg_q.buffer_size <= cfg_wdata[7:0];
				uart_rut_pkg::REG_EOL_ENABLE:  cfg_q.eol_enable  <= cfg_wdata[0];
				uart_rut_pkg::REG_EOL_LENGTH:  cfg_q.eol_length  <= cfg_wdata[2:0];
				uart_rut_pkg::REG_EOL_PATTERN: cfg_q.eol_pattern <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign adv      = v_s1 && (!v_s2 || m_tready);
	assign s_tready = !v_s1 || adv;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.cmd     <= s_tuser;
			item_s1.rx_byte <= s_tdata;
		end
	end

	uart_rut_ctrl #(
		.MAX_EOL (MAX_EOL)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= 1'b1;
		end else if (m_tready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_c;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = {7'd0, res_s2.done_count, res_s2.store_byte,
	                   res_s2.store_index, res_s2.store_valid};
	assign m_tlast  = res_s2.done_res;
	assign m_tuser  = res_s2.idle_seen;

endmodule

`default_nettype wire

@@ design/uart_rut_match.sv @@
`default_nettype none

module uart_rut_match #(
	parameter int MAX_EOL = 4,
	parameter int HIST_D  = 3
) (
	input  wire logic [7:0]          newest,
	input  wire logic [8*HIST_D-1:0] hist,
	input  wire logic [31:0]         pattern,
	input  wire logic [2:0]          length,
	input  wire logic [7:0]          count,
	output      logic                match
);

	logic [3:0]         n_raw;
	logic [3:0]         n_eff;
	logic [MAX_EOL-1:0] ok;

	always_comb begin
		n_raw = (length == 3'd0) ? 4'd1 : {1'b0, length};
		n_eff = (n_raw > 4'(MAX_EOL)) ? 4'(MAX_EOL) : n_raw;
	end

	for (genvar k = 0; k < MAX_EOL; k++) begin : g_cmp
		if (k == 0) begin : g_newest
			assign ok[k] = (newest == pattern[7:0]);
		end else if (k < 4) begin : g_pat
			assign ok[k] = (hist[8*(k-1) +: 8] == pattern[8*k +: 8]) || (4'(k) >= n_eff);
		end else begin : g_zero
			assign ok[k] = (hist[8*(k-1) +: 8] == 8'd0) || (4'(k) >= n_eff);
		end
	end

	assign match = (&ok) && (count >= {4'd0, n_eff});

endmodule

`default_nettype wire

@@ design/uart_rut_ctrl.sv @@
`default_nettype none

module uart_rut_ctrl #(
	parameter int MAX_EOL = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire uart_rut_pkg::item_t item,
	input  wire uart_rut_pkg::cfg_t  cfg,
	output      uart_rut_pkg::res_t  res
);

	localparam int HIST_D = (MAX_EOL > 1) ? MAX_EOL - 1 : 1;

	logic [7:0]          byte_count_q;
	logic                armed_q;
	logic                match_active_q;
	logic [8*HIST_D-1:0] hist_q;

	logic [7:0]          cnt_inc;
	logic                stores;
	logic                full;
	logic                match;
	logic                term;
	logic                done;

	logic [7:0]          byte_count_d;
	logic                armed_d;
	logic                match_active_d;
	logic [8*HIST_D-1:0] hist_d;

	uart_rut_match #(
		.MAX_EOL (MAX_EOL),
		.HIST_D  (HIST_D)
	) u_match (
		.newest  (item.rx_byte),
		.hist    (hist_q),
		.pattern (cfg.eol_pattern),
		.length  (cfg.eol_length),
		.count   (cnt_inc),
		.match   (match)
	);

	always_comb begin
		stores  = byte_count_q < cfg.buffer_size;
		cnt_inc = (byte_count_q != uart_rut_pkg::COUNT_MAX) ? byte_count_q + 8'd1 : byte_count_q;
		full    = cnt_inc >= cfg.buffer_size;
		term    = !full && match_active_q && match;
		done    = full || term;
	end

	always_comb begin
		res            = '0;
		byte_count_d   = byte_count_q;
		armed_d        = armed_q;
		match_active_d = match_active_q;
		hist_d         = hist_q;
		unique case (item.cmd)
			uart_rut_pkg::CMD_START: begin
				byte_count_d   = 8'd0;
				armed_d        = 1'b1;
				match_active_d = cfg.eol_enable;
				hist_d         = '0;
			end
			uart_rut_pkg::CMD_BYTE: begin
				if (armed_q) begin
					if (stores) begin
						res.store_valid = 1'b1;
						res.store_index = byte_count_q;
						res.store_byte  = item.rx_byte;
					end
					if (done) begin
						res.done_res = 1'b1;
						res.done_count = cnt_inc;
					end
					byte_count_d = done ? 8'd0 : cnt_inc;
					armed_d      = !done;
					if (term) begin
						match_active_d = 1'b0;
					end
					if (MAX_EOL > 2) begin
						hist_d = {hist_q[8*HIST_D-9:0], item.rx_byte};
					end else if (MAX_EOL == 2) begin
						hist_d = item.rx_byte;
					end
				end
			end
			uart_rut_pkg::CMD_IDLE: begin
				res.idle_seen = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= 8'd0;
			armed_q        <= 1'b0;
			match_active_q <= 1'b0;
			hist_q         <= '0;
		end else if (fire) begin
			byte_count_q   <= byte_count_d;
			armed_q        <= armed_d;
			match_active_q <= match_active_d;
			hist_q         <= hist_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_done_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.done_res |=> !armed_q && byte_count_q == 8'd0)
		else $error("completion did not disarm and clear the count");

	a_start_arms: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.cmd == uart_rut_pkg::CMD_START |=> armed_q && byte_count_q == 8'd0)
		else $error("start did not arm reception");

	a_store_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.store_valid |-> res.store_index < cfg.buffer_size && !res.idle_seen)
		else $error("store beyond buffer size");

	a_idle_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!armed_q |-> byte_count_q == 8'd0)
		else $error("count nonzero while disarmed");
`endif

endmodule

`default_nettype wire
